[sv/rpd_pkg.sv]
package rpd_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COORD_BITS_DEF = 32;
    // fraction bits of the unit direction vector
    localparam int UNIT_BITS      = 30;
    localparam int REG_IDX_BITS   = 3;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_CENTER_X      = 3'd0,
        REG_CENTER_Y      = 3'd1,
        REG_CENTER_Z      = 3'd2,
        REG_RAISE_GAIN    = 3'd3,
        REG_RADIAL_OFFSET = 3'd4
    } t_reg_idx;

endpackage

[sv/rpd_in_if.sv]
interface rpd_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] point_z;
    logic signed [W-1:0] scalar_value;

    modport source(output valid, point_x, point_y, point_z, scalar_value, input ready);
    modport sink(input valid, point_x, point_y, point_z, scalar_value, output ready);
endinterface

[sv/rpd_out_if.sv]
interface rpd_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] moved_x;
    logic signed [W-1:0] moved_y;
    logic signed [W-1:0] moved_z;
    logic                at_center;
    logic                saturated;

    modport source(output valid, moved_x, moved_y, moved_z, at_center, saturated,
                   input ready);
    modport sink(input valid, moved_x, moved_y, moved_z, at_center, saturated,
                 output ready);
endinterface

[sv/rpd_front.sv]
module rpd_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic signed [W-1:0]   i_p [3],
    input  logic signed [W-1:0]   i_v,
    input  logic signed [W-1:0]   i_c [3],
    input  logic signed [W-1:0]   i_gain,
    input  logic signed [W-1:0]   i_off,
    output logic                  o_vld,
    output logic [2*rpd_pkg::UNIT_BITS+1:0] o_sum,
    output logic [rpd_pkg::UNIT_BITS-1:0]   o_m [3],
    output logic signed [W-1:0]   o_p [3],
    output logic                  o_neg [3],
    output logic signed [2*W:0]   o_k,
    output logic                  o_atc
);
    import rpd_pkg::*;

    localparam int KW  = 2 * W + 1;
    localparam int BLW = $clog2(W + 2);
    localparam int NST = 5;
    localparam int SW  = 2 * UNIT_BITS + 2;

    // stage 1: offset from center, magnitudes, coefficient
    logic signed [W:0]     d [3];
    logic [W:0]            mag [3];
    logic signed [2*W-1:0] gv;
    logic signed [KW-1:0]  ko;
    logic signed [KW-1:0]  kk;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d[i]   = {i_p[i][W-1], i_p[i]} - {i_c[i][W-1], i_c[i]};
            mag[i] = d[i][W] ? (~d[i] + 1'b1) : d[i];
        end
        gv = i_gain * i_v;
        ko = KW'(i_off) <<< F;
        kk = KW'(gv) + ko;
    end

    logic [NST-1:0]        r_vld;
    logic signed [W-1:0]   r_p [NST][3];
    logic                  r_neg [NST][3];
    logic signed [KW-1:0]  r_k [NST];
    logic                  r_atc [NST];
    logic [W:0]            r1_m [3];
    logic [W:0]            r2_m [3];
    logic [BLW-1:0]        r2_bl;
    logic [UNIT_BITS-1:0]  r3_m [3];
    logic [UNIT_BITS-1:0]  r4_m [3];
    logic [UNIT_BITS-1:0]  r5_m [3];
    logic [2*UNIT_BITS-1:0] r4_sq [3];
    logic [SW-1:0]         r5_sum;

    // stage 2: bit length of the largest magnitude
    logic [W:0]            or_all;
    logic [BLW-1:0]        n_bl;

    always_comb begin
        or_all = r1_m[0] | r1_m[1] | r1_m[2];
        n_bl   = '0;
        for (int j = 0; j <= W; j++) begin
            if (or_all[j]) begin
                n_bl = BLW'(j + 1);
            end
        end
    end

    // stage 3: common shift into [2^29, 2^30)
    logic [W+UNIT_BITS:0]  ext [3];
    logic [W+UNIT_BITS:0]  shd [3];
    logic [UNIT_BITS-1:0]  n_m30 [3];
    int                    sh;

    always_comb begin
        sh = int'(r2_bl) - UNIT_BITS;
        for (int i = 0; i < 3; i++) begin
            ext[i] = (W + UNIT_BITS + 1)'(r2_m[i]);
            if (sh > 0) begin
                shd[i] = ext[i] >> sh;
            end else begin
                shd[i] = ext[i] << (-sh);
            end
            n_m30[i] = shd[i][UNIT_BITS-1:0];
        end
    end

    // advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p[0][i]   <= i_p[i];
                r_neg[0][i] <= d[i][W];
                r1_m[i]     <= mag[i];
                r2_m[i]     <= r1_m[i];
                r3_m[i]     <= n_m30[i];
                r4_m[i]     <= r3_m[i];
                r5_m[i]     <= r4_m[i];
                r4_sq[i]    <= r3_m[i] * r3_m[i];
            end
            r_k[0]   <= kk;
            r_atc[0] <= (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
            for (int s = 1; s < NST; s++) begin
                r_p[s]   <= r_p[s-1];
                r_neg[s] <= r_neg[s-1];
                r_k[s]   <= r_k[s-1];
                r_atc[s] <= r_atc[s-1];
            end
            r2_bl  <= n_bl;
            r5_sum <= SW'(r4_sq[0]) + SW'(r4_sq[1]) + SW'(r4_sq[2]);
        end
    end

    assign o_vld = r_vld[NST-1];
    assign o_sum = r5_sum;
    assign o_m   = r5_m;
    assign o_p   = r_p[NST-1];
    assign o_neg = r_neg[NST-1];
    assign o_k   = r_k[NST-1];
    assign o_atc = r_atc[NST-1];
endmodule

[sv/rpd_sqrt.sv]
module rpd_sqrt #(
    parameter int SBW = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic [2*rpd_pkg::UNIT_BITS+1:0]  i_x,
    input  logic [SBW-1:0]                   i_sb,
    output logic                             o_vld,
    output logic [rpd_pkg::UNIT_BITS:0]      o_root,
    output logic [SBW-1:0]                   o_sb
);
    import rpd_pkg::*;

    localparam int NS = UNIT_BITS + 1;
    localparam int XW = 2 * NS;
    localparam int RW = NS + 3;

    logic [NS-1:0]  r_vld;
    logic [XW-1:0]  r_x [NS];
    logic [RW-1:0]  r_rem [NS];
    logic [NS-1:0]  r_root [NS];
    logic [SBW-1:0] r_sb [NS];

    // one root bit per stage, two radicand bits consumed
    for (genvar s = 0; s < NS; s++) begin : g_step
        logic [XW-1:0] x_in;
        logic [RW-1:0] rem_in;
        logic [NS-1:0] root_in;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic          ge;

        if (s == 0) begin : g_first
            assign x_in    = i_x;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = r_x[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
        end

        assign rem_sh = {rem_in[RW-3:0], x_in[XW-1 -: 2]};
        assign trial  = RW'({root_in, 2'b01});
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s]    <= x_in << 2;
                r_rem[s]  <= ge ? (rem_sh - trial) : rem_sh;
                r_root[s] <= {root_in[NS-2:0], ge};
                r_sb[s]   <= (s == 0) ? i_sb : r_sb[s == 0 ? 0 : s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_root = r_root[NS-1];
    assign o_sb   = r_sb[NS-1];
endmodule

[sv/rpd_div.sv]
module rpd_div #(
    parameter int SBW = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [rpd_pkg::UNIT_BITS:0]   i_n,
    input  logic [rpd_pkg::UNIT_BITS-1:0] i_m [3],
    input  logic [SBW-1:0]                i_sb,
    output logic                          o_vld,
    output logic [rpd_pkg::UNIT_BITS:0]   o_u [3],
    output logic [SBW-1:0]                o_sb
);
    import rpd_pkg::*;

    localparam int NQ   = UNIT_BITS + 1;
    localparam int NUMW = 2 * UNIT_BITS + 1;
    localparam int NST  = NQ + 1;

    logic [NST-1:0]  r_vld;
    logic [NQ-1:0]   r_n [NST];
    logic [SBW-1:0]  r_sb [NST];
    logic [NQ:0]     r_rem [NST][3];
    logic [NQ-1:0]   r_low [NST][3];
    logic [NQ-1:0]   r_q [NST][3];

    // stage 0: rounded numerator, split into the first remainder and feed bits
    logic [NUMW-1:0] num [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i] = (NUMW'(i_m[i]) << UNIT_BITS) + NUMW'(i_n >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]  <= i_n;
            r_sb[0] <= i_sb;
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= (NQ + 1)'(num[i][NUMW-1:NQ]);
                r_low[0][i] <= num[i][NQ-1:0];
                r_q[0][i]   <= '0;
            end
        end
    end

    // one quotient bit per stage and lane
    for (genvar s = 1; s < NST; s++) begin : g_step
        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [NQ:0] rem_sh;
            logic        ge;

            assign rem_sh = {r_rem[s-1][i][NQ-1:0], r_low[s-1][i][NQ-1]};
            assign ge     = rem_sh >= {1'b0, r_n[s-1]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s][i] <= ge ? (rem_sh - {1'b0, r_n[s-1]}) : rem_sh;
                    r_low[s][i] <= r_low[s-1][i] << 1;
                    r_q[s][i]   <= {r_q[s-1][i][NQ-2:0], ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[s]  <= r_n[s-1];
                r_sb[s] <= r_sb[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    assign o_vld = r_vld[NST-1];
    assign o_u   = r_q[NST-1];
    assign o_sb  = r_sb[NST-1];
endmodule

[sv/rpd_move.sv]
module rpd_move #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [rpd_pkg::UNIT_BITS:0] i_u [3],
    input  logic                        i_neg [3],
    input  logic signed [2*W:0]         i_k,
    input  logic signed [W-1:0]         i_p [3],
    input  logic                        i_atc,
    output logic                        o_vld,
    output logic signed [W-1:0]         o_moved [3],
    output logic                        o_atc,
    output logic                        o_sat
);
    import rpd_pkg::*;

    localparam int KW = 2 * W + 1;
    localparam int KL = KW / 2;
    localparam int KH = KW - KL;
    localparam int UW = UNIT_BITS + 2;
    localparam int PW = KW + UW + 1;
    localparam logic signed [PW-1:0] MAXV = (PW'(1) <<< (W - 1)) - PW'(1);
    localparam logic signed [PW-1:0] MINV = -(PW'(1) <<< (W - 1));
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (F + UNIT_BITS - 1);

    // stage 1: signed unit component times coefficient halves
    logic signed [UW-1:0]      su [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            su[i] = i_neg[i] ? -$signed({1'b0, i_u[i]}) : $signed({1'b0, i_u[i]});
        end
    end

    logic [2:0]                 r_vld;
    logic signed [KL+UW:0]      r1_pl [3];
    logic signed [KH+UW-1:0]    r1_ph [3];
    logic signed [PW-1:0]       r2_tot [3];
    logic signed [W-1:0]        r1_p [3];
    logic signed [W-1:0]        r2_p [3];
    logic                       r1_atc;
    logic                       r2_atc;
    logic signed [W-1:0]        r_moved [3];
    logic                       r_atc;
    logic                       r_sat;

    // stage 3: round off, add the point, clip
    logic signed [PW-1:0]       res [3];
    logic signed [W-1:0]        n_moved [3];
    logic                       n_sat;

    always_comb begin
        n_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            res[i] = (r2_tot[i] >>> (F + UNIT_BITS)) + PW'(r2_p[i]);
            if (r2_atc) begin
                n_moved[i] = r2_p[i];
            end else if (res[i] > MAXV) begin
                n_moved[i] = MAXV[W-1:0];
                n_sat      = 1'b1;
            end else if (res[i] < MINV) begin
                n_moved[i] = MINV[W-1:0];
                n_sat      = 1'b1;
            end else begin
                n_moved[i] = res[i][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_pl[i]   <= $signed({1'b0, i_k[KL-1:0]}) * su[i];
                r1_ph[i]   <= $signed(i_k[KW-1:KL]) * su[i];
                r1_p[i]    <= i_p[i];
                r2_tot[i]  <= (PW'(r1_ph[i]) <<< KL) + PW'(r1_pl[i]) + HALF;
                r2_p[i]    <= r1_p[i];
                r_moved[i] <= n_moved[i];
            end
            r1_atc <= i_atc;
            r2_atc <= r1_atc;
            r_atc  <= r2_atc;
            r_sat  <= n_sat;
        end
    end

    assign o_vld   = r_vld[2];
    assign o_moved = r_moved;
    assign o_atc   = r_atc;
    assign o_sat   = r_sat;
endmodule

[sv/radial_point_displace.sv]
// Channel   Modport  Direction  Contents
// i_pt      sink     in         point_x, point_y, point_z, scalar_value
// o_res     source   out        moved_x, moved_y, moved_z, at_center, saturated
// i_cfg_*   -        in         write enable, register index, data
//
// One item enters per cycle unless the pipeline stalls. Front, square root,
// divide and move (output register included) follow in order; the square-root
// and divider pipelines, one result bit per stage, set the depth.
// Reset clears all valid bits and loads the register reset values.
// A result not taken stalls the whole pipeline; i_pt.ready drops only while
// the output register holds an untaken item.
module radial_point_displace #(
    parameter int COORD_BITS = rpd_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rpd_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rpd_pkg::REG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [COORD_BITS-1:0]             i_cfg_data,
    rpd_in_if.sink                            i_pt,
    rpd_out_if.source                         o_res
);
    import rpd_pkg::*;

    localparam int W   = COORD_BITS;
    localparam int KW  = 2 * W + 1;
    localparam int SB1 = 3 * W + 3 + KW + 1 + 3 * UNIT_BITS;
    localparam int SB2 = 3 * W + 3 + KW + 1;

    logic signed [W-1:0] r_center [3];
    logic signed [W-1:0] r_gain;
    logic signed [W-1:0] r_off;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
            r_gain      <= W'(1) << FRAC_BITS;
            r_off       <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CENTER_X:      r_center[0] <= i_cfg_data;
                REG_CENTER_Y:      r_center[1] <= i_cfg_data;
                REG_CENTER_Z:      r_center[2] <= i_cfg_data;
                REG_RAISE_GAIN:    r_gain      <= i_cfg_data;
                REG_RADIAL_OFFSET: r_off       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance everything while the output register is free or being taken
    logic en;
    assign en         = !o_res.valid || o_res.ready;
    assign i_pt.ready = en;

    logic signed [W-1:0] pin [3];
    assign pin[0] = i_pt.point_x;
    assign pin[1] = i_pt.point_y;
    assign pin[2] = i_pt.point_z;

    logic                         f_vld;
    logic [2*UNIT_BITS+1:0]       f_sum;
    logic [UNIT_BITS-1:0]         f_m [3];
    logic signed [W-1:0]          f_p [3];
    logic                         f_neg [3];
    logic signed [KW-1:0]         f_k;
    logic                         f_atc;

    rpd_front #(.W(W), .F(FRAC_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(i_pt.valid && en), .i_p(pin), .i_v(i_pt.scalar_value),
        .i_c(r_center), .i_gain(r_gain), .i_off(r_off),
        .o_vld(f_vld), .o_sum(f_sum), .o_m(f_m), .o_p(f_p), .o_neg(f_neg),
        .o_k(f_k), .o_atc(f_atc)
    );

    logic [SB1-1:0]        sb1_in, sb1_out;
    logic                  s_vld;
    logic [UNIT_BITS:0]    s_root;

    assign sb1_in = {f_p[0], f_p[1], f_p[2], f_neg[0], f_neg[1], f_neg[2], f_k, f_atc,
                     f_m[0], f_m[1], f_m[2]};

    rpd_sqrt #(.SBW(SB1)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(f_vld),
        .i_x(f_sum), .i_sb(sb1_in),
        .o_vld(s_vld), .o_root(s_root), .o_sb(sb1_out)
    );

    logic [UNIT_BITS-1:0]  s_m [3];
    logic [SB2-1:0]        sb2_in, sb2_out;
    assign s_m[0] = sb1_out[3*UNIT_BITS-1:2*UNIT_BITS];
    assign s_m[1] = sb1_out[2*UNIT_BITS-1:UNIT_BITS];
    assign s_m[2] = sb1_out[UNIT_BITS-1:0];
    assign sb2_in = sb1_out[SB1-1:3*UNIT_BITS];

    logic                  q_vld;
    logic [UNIT_BITS:0]    q_u [3];

    rpd_div #(.SBW(SB2)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(s_vld),
        .i_n(s_root), .i_m(s_m), .i_sb(sb2_in),
        .o_vld(q_vld), .o_u(q_u), .o_sb(sb2_out)
    );

    logic signed [W-1:0]   q_p [3];
    logic                  q_neg [3];
    logic signed [KW-1:0]  q_k;
    logic                  q_atc;
    assign q_p[0]   = sb2_out[SB2-1 -: W];
    assign q_p[1]   = sb2_out[SB2-W-1 -: W];
    assign q_p[2]   = sb2_out[SB2-2*W-1 -: W];
    assign q_neg[0] = sb2_out[KW+3];
    assign q_neg[1] = sb2_out[KW+2];
    assign q_neg[2] = sb2_out[KW+1];
    assign q_k      = sb2_out[KW:1];
    assign q_atc    = sb2_out[0];

    logic signed [W-1:0]   m_out [3];

    rpd_move #(.W(W), .F(FRAC_BITS)) u_move (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(q_vld),
        .i_u(q_u), .i_neg(q_neg), .i_k(q_k), .i_p(q_p), .i_atc(q_atc),
        .o_vld(o_res.valid), .o_moved(m_out), .o_atc(o_res.at_center),
        .o_sat(o_res.saturated)
    );

    assign o_res.moved_x = m_out[0];
    assign o_res.moved_y = m_out[1];
    assign o_res.moved_z = m_out[2];

`ifndef NO_ASSERTIONS
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

    a_center_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.at_center |-> !o_res.saturated)
        else $error("at_center item flagged saturated");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.saturated |->
            o_res.moved_x == CMAX || o_res.moved_x == CMIN ||
            o_res.moved_y == CMAX || o_res.moved_y == CMIN ||
            o_res.moved_z == CMAX || o_res.moved_z == CMIN)
        else $error("saturated item has no clipped coordinate");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) && i_rst_n |-> !o_res.valid)
        else $error("result valid right after reset");
`endif
endmodule
